@@ rtl/sscc_pkg.sv @@
// Shared types, constants and byte-wide helper functions for the scrambler seed search.
// Depends on nothing; every other file imports it, except the generic frame memory.
`default_nettype none

package sscc_pkg;

	localparam int unsigned HDR_BYTES   = 3;
	localparam int unsigned CHK_BYTES   = 4;
	localparam logic [31:0] CRC_POLY    = 32'h04c1_1db7;
	localparam logic [31:0] CRC_INIT    = 32'hffff_ffff;
	localparam logic [7:0]  SCR_TAPS    = 8'h8e;
	localparam logic [7:0]  GATE_MASK   = 8'hf8;
	localparam logic [7:0]  LEN_HI_MASK = 8'h07;
	localparam logic [7:0]  SEED_FIRST  = 8'h01;
	localparam logic [7:0]  SEED_LAST   = 8'hff;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_LEN_ERR  = 2'd1,
		ST_GATE_ERR = 2'd2,
		ST_NO_SEED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_CHECK,
		T_SEARCH,
		T_RESULT
	} top_state_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_CMP
	} srch_state_t;

	// control from the top level to the search engine
	typedef struct packed {
		logic        start;
		logic [10:0] plen;
	} srch_ctl_t;

	// report from the search engine
	typedef struct packed {
		logic       done;
		logic       found;
		logic [7:0] seed;
	} srch_res_t;

	typedef struct packed {
		logic [7:0] key;
		logic [7:0] lfsr;
	} key_t;

	// Eight descrambler steps: keystream comes from bit 7, MSB first.
	function automatic key_t key_byte(input logic [7:0] lfsr);
		logic [7:0] r;
		key_t       res;
		r = lfsr;
		res.key = '0;
		for (int b = 0; b < 8; b++) begin
			res.key[7-b] = r[7];
			r = {r[6:0], ^(r & SCR_TAPS)};
		end
		res.lfsr = r;
		return res;
	endfunction

	// One byte of CRC-32/MPEG-2, MSB first.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] d);
		logic [31:0] c;
		c = crc ^ {d, 24'h0};
		for (int b = 0; b < 8; b++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/sscc_frame_mem.sv @@
// Frame byte store: one write port, one read port with registered read data.
// Depends on nothing.
`default_nettype none

module sscc_frame_mem #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = 9
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic [7:0]         rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/sscc_search.sv @@
// Seed search engine: streams the stored payload and check bytes once per seed
// through the descrambler and CRC. Depends on sscc_pkg and reads sscc_frame_mem.
`default_nettype none

module sscc_search
	import sscc_pkg::*;
#(
	parameter int unsigned AW = 9
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire srch_ctl_t     ctl,
	output srch_res_t          res,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  wire logic [7:0]    rd_data
);

	srch_state_t state_q, state_d;

	logic [7:0]  seed_q;
	logic [7:0]  lfsr_q;
	logic [31:0] crc_q;
	logic [31:0] chk_q;
	logic [11:0] idx_q;
	logic [10:0] plen_q;
	logic [11:0] total_q;
	logic        valid_s1;
	logic        pay_s1;
	logic        last_s1;

	logic        issue;
	logic        match;
	logic        finish;
	logic [12:0] addr_sum;
	key_t        kb;
	logic [7:0]  d;

	assign issue    = (state_q == S_RUN) && (idx_q < total_q);
	assign match    = (crc_q == chk_q);
	assign finish   = (state_q == S_CMP) && (match || (seed_q == SEED_LAST));
	assign addr_sum = {1'b0, idx_q} + 13'(HDR_BYTES);
	assign kb       = key_byte(lfsr_q);
	assign d        = rd_data ^ kb.key;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (ctl.start) begin
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				if (valid_s1 && last_s1) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				state_d = finish ? S_IDLE : S_RUN;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rd_en     = issue;
		rd_addr   = addr_sum[AW-1:0];
		res.done  = finish;
		res.found = match;
		res.seed  = seed_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		pay_s1  <= ({1'b0, idx_q} < {1'b0, 1'b0, plen_q});
		last_s1 <= (idx_q == total_q - 12'd1);

		if (state_q == S_IDLE && ctl.start) begin
			seed_q  <= SEED_FIRST;
			plen_q  <= ctl.plen;
			total_q <= {1'b0, ctl.plen} + 12'(CHK_BYTES);
			lfsr_q  <= SEED_FIRST;
			crc_q   <= CRC_INIT;
			chk_q   <= '0;
			idx_q   <= '0;
		end else if (state_q == S_CMP && !finish) begin
			// advance to the next seed and restart the stream
			seed_q <= seed_q + 8'd1;
			lfsr_q <= seed_q + 8'd1;
			crc_q  <= CRC_INIT;
			chk_q  <= '0;
			idx_q  <= '0;
		end else begin
			if (issue) begin
				idx_q <= idx_q + 12'd1;
			end
			if (valid_s1) begin
				lfsr_q <= kb.lfsr;
				if (pay_s1) begin
					crc_q <= crc_byte(crc_q, d);
				end else begin
					chk_q <= {chk_q[23:0], d};
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/scrambler_seed_search_crc_check.sv @@
// Capture of one frame into the byte store, header and length checks, seed search
// control and the output register. Depends on sscc_pkg, sscc_frame_mem, sscc_search.
`default_nettype none

// A word is accepted whenever in_valid is high while a capture is collected; bytes past
// BUFFER_BYTES are dropped. The word marked capture_end starts the header
// checks. A frame that passes them goes to the seed search, which streams the
// payload and check bytes out of the single-read-port byte store once per seed:
// payload_length + 4 reads, a wait for the registered read data, then the compare,
// for up to 255 seeds. The result then moves into the output register once that
// register is free or being emptied. Input is stalled from capture_end until the
// result has entered the output register; new words are taken while that result
// still waits on out_stall.
module scrambler_seed_search_crc_check
	import sscc_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  frame_byte,
	input  wire logic        first_byte,
	input  wire logic        capture_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [7:0]       channel,
	output logic [7:0]       seed,
	output logic [10:0]      payload_length
);

	localparam int unsigned AddrW = $clog2(BUFFER_BYTES);
	localparam int unsigned CntW  = $clog2(BUFFER_BYTES + 1);

	top_state_t state_q, state_d;

	logic [CntW-1:0] count_q;
	logic [CntW-1:0] end_cnt_q;
	logic [7:0]      ch_q;
	logic [7:0]      h1_q;
	logic [7:0]      h2_q;
	status_t         pend_status_q;
	logic [7:0]      pend_seed_q;
	logic            out_valid_q;
	status_t         status_q;
	logic [7:0]      channel_q;
	logic [7:0]      seed_q;
	logic [10:0]     plen_out_q;

	logic            in_acc;
	logic [CntW-1:0] cnt_eff;
	logic            room;
	logic [CntW-1:0] cnt_new;
	logic            mem_wr_en;
	logic            mem_rd_en;
	logic [AddrW-1:0] mem_rd_addr;
	logic [7:0]      mem_rd_data;
	logic [10:0]     plen;
	logic            too_short;
	logic            gate_bad;
	logic            len_bad;
	status_t         chk_status;
	logic            load_out;
	srch_ctl_t       srch_ctl;
	srch_res_t       srch_res;

	assign in_acc  = in_valid && !in_stall;
	assign cnt_eff = first_byte ? '0 : count_q;
	assign room    = (cnt_eff < CntW'(BUFFER_BYTES));
	assign cnt_new = cnt_eff + CntW'(room);
	assign mem_wr_en = in_acc && room;

	assign plen      = {h1_q[2:0], h2_q};
	assign too_short = (end_cnt_q < CntW'(HDR_BYTES + CHK_BYTES));
	assign gate_bad  = ((h1_q & GATE_MASK) != 8'h00);
	assign len_bad   = (plen == 11'd0) ||
		((13'(plen) + 13'(HDR_BYTES + CHK_BYTES)) > 13'(end_cnt_q));

	always_comb begin
		if (too_short) begin
			chk_status = ST_LEN_ERR;
		end else if (gate_bad) begin
			chk_status = ST_GATE_ERR;
		end else if (len_bad) begin
			chk_status = ST_LEN_ERR;
		end else begin
			chk_status = ST_OK;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: begin
				if (in_acc && capture_end) begin
					state_d = T_CHECK;
				end
			end
			T_CHECK: begin
				state_d = (chk_status == ST_OK) ? T_SEARCH : T_RESULT;
			end
			T_SEARCH: begin
				if (srch_res.done) begin
					state_d = T_RESULT;
				end
			end
			T_RESULT: begin
				if (load_out) begin
					state_d = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != T_IDLE);
		load_out      = (state_q == T_RESULT) && (!out_valid_q || !out_stall);
		srch_ctl.start = (state_q == T_CHECK) && (chk_status == ST_OK);
		srch_ctl.plen  = plen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				// a capture end clears the count so the next word opens a new capture
				count_q <= capture_end ? '0 : cnt_new;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && capture_end) begin
			end_cnt_q <= cnt_new;
		end
		if (mem_wr_en && cnt_eff == CntW'(0)) begin
			ch_q <= frame_byte;
		end
		if (mem_wr_en && cnt_eff == CntW'(1)) begin
			h1_q <= frame_byte;
		end
		if (mem_wr_en && cnt_eff == CntW'(2)) begin
			h2_q <= frame_byte;
		end
		if (state_q == T_CHECK) begin
			pend_status_q <= chk_status;
			pend_seed_q   <= '0;
		end else if (state_q == T_SEARCH && srch_res.done) begin
			pend_status_q <= srch_res.found ? ST_OK : ST_NO_SEED;
			pend_seed_q   <= srch_res.found ? srch_res.seed : 8'h00;
		end
		if (load_out) begin
			status_q   <= pend_status_q;
			channel_q  <= ch_q;
			seed_q     <= pend_seed_q;
			plen_out_q <= (end_cnt_q >= CntW'(HDR_BYTES)) ? plen : 11'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign channel        = channel_q;
	assign seed           = seed_q;
	assign payload_length = plen_out_q;

	// Writes happen only while collecting and reads only while searching,
	// so the two ports never touch the store in the same cycle.
	sscc_frame_mem #(
		.DEPTH(BUFFER_BYTES),
		.AW   (AddrW)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(cnt_eff[AddrW-1:0]),
		.wr_data(frame_byte),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	sscc_search #(
		.AW(AddrW)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (srch_ctl),
		.res    (srch_res),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

`ifndef SYNTHESIS
	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_rd_en && mem_wr_en))
		else $error("frame store read and written in the same cycle");

	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		srch_res.done |-> (state_q == T_SEARCH))
		else $error("search finished outside the search phase");

	a_ok_has_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_OK) |-> (seed_q != 8'h00))
		else $error("ok result without a seed");
`endif

endmodule

`default_nettype wire

@@ tb/seed_search_checker.sv @@
// Watches both word channels of the seed search block, predicts each capture's
// result and compares it field by field. Depends on sscc_pkg for codes and constants.

module seed_search_checker
	import sscc_pkg::*;
#(
	parameter int unsigned BUFFER_BYTES = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  frame_byte,
	input  wire logic        first_byte,
	input  wire logic        capture_end,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  status,
	input  wire logic [7:0]  channel,
	input  wire logic [7:0]  seed,
	input  wire logic [10:0] payload_length,
	output int               mismatches,
	output int               verdicts_checked,
	output int               verdicts_open
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  channel;
		logic [7:0]  seed;
		logic [10:0] plen;
	} verdict_t;

	logic [7:0]  capture_bytes [BUFFER_BYTES];
	int unsigned capture_fill = 0;
	verdict_t    verdict_q [$];
	int          bad_fields = 0;
	int          checked_cnt = 0;

	// Descramble payload and check word with one seed and test the CRC against the check.
	function automatic bit crc_holds(input int s, input int len);
		logic [7:0]  sreg;
		logic [7:0]  d;
		logic [31:0] acc;
		logic [31:0] tail;
		sreg = s[7:0];
		acc = CRC_INIT;
		tail = '0;
		for (int i = 0; i < len + CHK_BYTES; i++) begin
			d = capture_bytes[i + HDR_BYTES];
			for (int b = 7; b >= 0; b--) begin
				d[b] = d[b] ^ sreg[7];
				sreg = {sreg[6:0], ^(sreg & SCR_TAPS)};
			end
			if (i < len) begin
				acc = acc ^ {d, 24'h0};
				repeat (8) acc = {acc[30:0], 1'b0} ^ (acc[31] ? CRC_POLY : 32'h0);
			end else begin
				tail = {tail[23:0], d};
			end
		end
		return acc == tail;
	endfunction

	// Header checks, then the first seed whose CRC matches.
	function automatic verdict_t search_capture();
		verdict_t v;
		v = '0;
		v.status = ST_NO_SEED;
		if (capture_fill >= 1)
			v.channel = capture_bytes[0];
		if (capture_fill >= HDR_BYTES)
			v.plen = {capture_bytes[1][2:0], capture_bytes[2]};
		if (capture_fill < HDR_BYTES + CHK_BYTES) begin
			v.status = ST_LEN_ERR;
		end else if ((capture_bytes[1] & GATE_MASK) != 0) begin
			v.status = ST_GATE_ERR;
		end else if (v.plen == 0 || HDR_BYTES + v.plen + CHK_BYTES > capture_fill) begin
			v.status = ST_LEN_ERR;
		end else begin
			for (int s = SEED_FIRST; s <= SEED_LAST; s++) begin
				if (v.status == ST_NO_SEED && crc_holds(s, v.plen)) begin
					v.status = ST_OK;
					v.seed = s[7:0];
				end
			end
		end
		return v;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
			bad_fields++;
		end
	endtask

	always @(posedge clk) begin : watch
		verdict_t want;
		if (arst_n) begin
			// compare before predicting: a result never belongs to a word taken at the same edge
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: expected no result, got status %0d channel %0d seed %0d length %0d",
						$time, status, channel, seed, payload_length);
					bad_fields++;
				end else begin
					want = verdict_q.pop_front();
					check_field("status", want.status, status);
					check_field("channel", want.channel, channel);
					check_field("seed", want.seed, seed);
					check_field("payload_length", want.plen, payload_length);
					checked_cnt++;
				end
			end
			if (in_valid && !in_stall) begin
				if (first_byte)
					capture_fill = 0;
				// drop words past the end of the store
				if (capture_fill < BUFFER_BYTES) begin
					capture_bytes[capture_fill] = frame_byte;
					capture_fill++;
				end
				if (capture_end) begin
					verdict_q.push_back(search_capture());
					capture_fill = 0;
				end
			end
		end
		mismatches <= bad_fields;
		verdicts_checked <= checked_cnt;
		verdicts_open <= verdict_q.size();
	end

endmodule

@@ tb/tb_top.sv @@
// Top of the seed search testbench: clock, reset, frame stimulus, output stalls and verdict.
// Depends on sscc_pkg, the scrambler_seed_search_crc_check block and seed_search_checker.

module tb_top
	import sscc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned BUFFER_BYTES   = 512;
	localparam int          WATCHDOG_LIMIT = 1000000;
	localparam int          DRAIN_CYCLES   = 32;
	localparam int          PHASE_WORDS    = 120;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  frame_byte = 8'h00;
	logic        first_byte = 1'b0;
	logic        capture_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [7:0]  channel;
	logic [7:0]  seed;
	logic [10:0] payload_length;

	int          mismatches;
	int          verdicts_checked;
	int          verdicts_open;

	int          src_idle_pct = 19;
	int          dst_idle_pct = 53;
	int          words_sent = 0;
	int          captures_sent = 0;
	int          quiet_cycles = 0;
	logic [7:0]  frame_q [$];

	scrambler_seed_search_crc_check #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.frame_byte(frame_byte),
		.first_byte(first_byte),
		.capture_end(capture_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.channel(channel),
		.seed(seed),
		.payload_length(payload_length)
	);

	seed_search_checker #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.frame_byte(frame_byte),
		.first_byte(first_byte),
		.capture_end(capture_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.channel(channel),
		.seed(seed),
		.payload_length(payload_length),
		.mismatches(mismatches),
		.verdicts_checked(verdicts_checked),
		.verdicts_open(verdicts_open)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < dst_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: watchdog, no word moved for %0d cycles", quiet_cycles);
			$display("tb_top: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// XOR the payload and check bytes with the keystream of one seed.
	task automatic scramble_body(input logic [7:0] key_seed, input int n);
		logic [7:0] sreg;
		logic [7:0] key;
		sreg = key_seed;
		key = '0;
		for (int i = 0; i < n; i++) begin
			for (int b = 0; b < 8; b++) begin
				key = {key[6:0], sreg[7]};
				sreg = {sreg[6:0], ^(sreg & SCR_TAPS)};
			end
			frame_q[HDR_BYTES + i] = frame_q[HDR_BYTES + i] ^ key;
		end
	endtask

	// Well-formed frame: clear header, random payload, CRC, scrambled; then random tail words.
	task automatic build_frame(input logic [7:0] chan, input logic [10:0] plen,
			input logic [7:0] key_seed, input int tail);
		logic [31:0] crc;
		logic [7:0]  d;
		frame_q.delete();
		frame_q.push_back(chan);
		frame_q.push_back({5'b0, plen[10:8]});
		frame_q.push_back(plen[7:0]);
		crc = CRC_INIT;
		for (int i = 0; i < plen; i++) begin
			d = 8'($urandom);
			frame_q.push_back(d);
			crc = crc ^ {d, 24'h0};
			for (int b = 0; b < 8; b++)
				crc = crc[31] ? ({crc[30:0], 1'b0} ^ CRC_POLY) : {crc[30:0], 1'b0};
		end
		for (int i = 3; i >= 0; i--)
			frame_q.push_back(crc[8*i +: 8]);
		scramble_body(key_seed, int'(plen) + int'(CHK_BYTES));
		repeat (tail) frame_q.push_back(8'($urandom));
	endtask

	task automatic send_word(input logic [7:0] b, input logic f, input logic e);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		frame_byte <= b;
		first_byte <= f;
		capture_end <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_frame(input bit mark_first);
		for (int i = 0; i < frame_q.size(); i++)
			send_word(frame_q[i], (i == 0) && mark_first, i == frame_q.size() - 1);
		captures_sent++;
	endtask

	task automatic random_capture();
		int         kind;
		int         plen;
		int         idx;
		logic [4:0] gbits;
		logic [7:0] hdr;
		kind = $urandom_range(99);
		plen = ($urandom_range(19) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
		if (kind < 90)
			build_frame(8'($urandom), 11'(plen),
				(kind >= 70 && kind < 75) ? 8'h00 : 8'($urandom_range(255, 1)),
				(kind < 60) ? $urandom_range(2) : 0);
		if (kind >= 60 && kind < 70) begin
			// flip one bit of payload or check: no seed should match
			idx = $urandom_range(frame_q.size() - 1, HDR_BYTES);
			frame_q[idx] = frame_q[idx] ^ (8'h01 << $urandom_range(7));
		end else if (kind >= 75 && kind < 82) begin
			gbits = 5'($urandom_range(31, 1));
			hdr = frame_q[1];
			frame_q[1] = {gbits, hdr[2:0]};
		end else if (kind >= 82 && kind < 90) begin
			// truncate so the length field no longer fits
			repeat ($urandom_range(3, 1)) void'(frame_q.pop_back());
		end else if (kind >= 90) begin
			frame_q.delete();
			repeat ($urandom_range(12, 1)) frame_q.push_back(8'($urandom));
		end
		if ($urandom_range(7) == 0) begin
			// stray words, then restart the capture
			repeat ($urandom_range(4, 1))
				send_word(8'($urandom), 1'($urandom_range(1)), 1'b0);
			send_frame(1'b1);
		end else begin
			send_frame($urandom_range(3) != 0);
		end
	endtask

	initial begin
		int phase_start;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// capture that starts without a first_byte mark, lowest seed
		build_frame(8'h00, 11'd1, SEED_FIRST, 0);
		send_frame(1'b0);
		// one word that both starts and ends a capture
		frame_q.delete();
		frame_q.push_back(8'hff);
		send_frame(1'b1);
		// header only, largest length field
		frame_q.delete();
		frame_q.push_back(8'h00);
		frame_q.push_back(8'h07);
		frame_q.push_back(8'hff);
		send_frame(1'b1);
		// all gate bits set
		build_frame(8'hff, 11'd1, 8'h80, 0);
		frame_q[1] = 8'hff;
		send_frame(1'b1);
		// zero payload length
		frame_q.delete();
		frame_q.push_back(8'h01);
		frame_q.push_back(8'h00);
		frame_q.push_back(8'h00);
		repeat (CHK_BYTES) frame_q.push_back(8'($urandom));
		send_frame(1'b1);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 19;
					dst_idle_pct = 53;
				end
				1: begin
					src_idle_pct = 53;
					dst_idle_pct = 19;
				end
				default: begin
					src_idle_pct = 0;
					dst_idle_pct = 0;
					// full store, words past its end, longest payload, last seed
					build_frame(8'($urandom), 11'(BUFFER_BYTES - HDR_BYTES - CHK_BYTES),
						SEED_LAST, 8);
					send_frame(1'b1);
				end
			endcase
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS)
				random_capture();
		end
		in_valid <= 1'b0;

		while (verdicts_checked < captures_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb_top: %0d words in %0d captures, %0d results compared", words_sent,
			captures_sent, verdicts_checked);
		$display("tb_top: header, gate, length, overflow and seed cases, three stall mixes");
		if (mismatches == 0 && verdicts_open == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
